FILE: rtl/core/anns_pkg.sv
// Shared types, codes and constants of the angular neighbour search block.
`default_nettype none
package anns_pkg;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NONE   = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  localparam logic CFG_RING_MIN = 1'b0;
  localparam logic CFG_RING_MAX = 1'b1;

  localparam int CORDIC_STEPS = 28;
  // x and y grow to 17 bits, times 2^14, plus CORDIC gain headroom
  localparam int CW = 34;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    begin
      case (i)
        5'd0:  r = 32'd536870912;
        5'd1:  r = 32'd316933406;
        5'd2:  r = 32'd167458907;
        5'd3:  r = 32'd85004756;
        5'd4:  r = 32'd42667331;
        5'd5:  r = 32'd21354465;
        5'd6:  r = 32'd10680862;
        5'd7:  r = 32'd5340245;
        5'd8:  r = 32'd2670163;
        5'd9:  r = 32'd1335087;
        5'd10: r = 32'd667544;
        5'd11: r = 32'd333772;
        5'd12: r = 32'd166886;
        5'd13: r = 32'd83443;
        5'd14: r = 32'd41721;
        5'd15: r = 32'd20860;
        5'd16: r = 32'd10430;
        5'd17: r = 32'd5215;
        5'd18: r = 32'd2607;
        5'd19: r = 32'd1303;
        5'd20: r = 32'd651;
        5'd21: r = 32'd325;
        5'd22: r = 32'd162;
        5'd23: r = 32'd81;
        5'd24: r = 32'd40;
        5'd25: r = 32'd20;
        5'd26: r = 32'd10;
        5'd27: r = 32'd5;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction

  // one pipelined CORDIC stage word
  typedef struct packed {
    logic          vld;
    logic          axis;
    logic [31:0]   axz;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic [31:0]   z;
    logic [31:0]   pt;
    logic          tag;
  } anns_cord_t;

endpackage
`default_nettype wire

FILE: rtl/core/anns_cordic.sv
// Pipelined vectoring CORDIC angle unit, one vector per cycle.
`default_nettype none
module anns_cordic
  import anns_pkg::*;
#(
  parameter int ANGLE_BITS = 16
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_vld,
  input  wire signed [16:0]    in_x,
  input  wire signed [16:0]    in_y,
  input  wire [31:0]           in_pt,
  input  wire                  in_tag,
  output logic                 out_vld,
  output logic [ANGLE_BITS:0]  out_ang,
  output logic [31:0]          out_pt,
  output logic                 out_tag
);

  anns_cord_t stg [0:CORDIC_STEPS];
  anns_cord_t s0;

  // set up axes and the half turn pre-rotation
  always_comb begin
    s0 = '0;
    s0.vld = in_vld;
    s0.pt = in_pt;
    s0.tag = in_tag;
    s0.cx = CW'(in_x) <<< 14;
    s0.cy = CW'(in_y) <<< 14;
    if (in_y == 0) begin
      s0.axis = 1'b1;
      s0.axz = (in_x < 0) ? 32'h8000_0000 : 32'h0;
    end else if (in_x == 0) begin
      s0.axis = 1'b1;
      s0.axz = (in_y > 0) ? 32'h4000_0000 : 32'hC000_0000;
    end
    if (in_x < 0) begin
      s0.cx = -s0.cx;
      s0.cy = -s0.cy;
      s0.z = 32'h8000_0000;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) stg[0].vld <= 1'b0;
    else stg[0].vld <= s0.vld;
    stg[0].axis <= s0.axis;
    stg[0].axz <= s0.axz;
    stg[0].cx <= s0.cx;
    stg[0].cy <= s0.cy;
    stg[0].z <= s0.z;
    stg[0].pt <= s0.pt;
    stg[0].tag <= s0.tag;
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
    anns_cord_t nx;
    always_comb begin
      nx = stg[i];
      if (stg[i].cy > 0) begin
        nx.cx = stg[i].cx + (stg[i].cy >>> i);
        nx.cy = stg[i].cy - (stg[i].cx >>> i);
        nx.z = stg[i].z + atan_turn(5'(i));
      end else begin
        nx.cx = stg[i].cx - (stg[i].cy >>> i);
        nx.cy = stg[i].cy + (stg[i].cx >>> i);
        nx.z = stg[i].z - atan_turn(5'(i));
      end
    end
    always_ff @(posedge clk) begin
      if (rst) stg[i+1].vld <= 1'b0;
      else stg[i+1].vld <= nx.vld;
      stg[i+1].axis <= nx.axis;
      stg[i+1].axz <= nx.axz;
      stg[i+1].cx <= nx.cx;
      stg[i+1].cy <= nx.cy;
      stg[i+1].z <= nx.z;
      stg[i+1].pt <= nx.pt;
      stg[i+1].tag <= nx.tag;
    end
  end

  // truncate and map a zero angle to a full turn
  logic [31:0] zf;
  logic [ANGLE_BITS-1:0] a;
  always_comb begin
    zf = stg[CORDIC_STEPS].axis ? stg[CORDIC_STEPS].axz : stg[CORDIC_STEPS].z;
    a = zf[31 -: ANGLE_BITS];
    out_ang = (a == '0) ? {1'b1, {ANGLE_BITS{1'b0}}} : {1'b0, a};
    out_vld = stg[CORDIC_STEPS].vld;
    out_pt = stg[CORDIC_STEPS].pt;
    out_tag = stg[CORDIC_STEPS].tag;
  end

endmodule
`default_nettype wire

FILE: rtl/core/anns_select.sv
// Ring filter and best-candidate selection over the angle stream.
`default_nettype none
module anns_select
  import anns_pkg::*;
#(
  parameter int ANGLE_BITS = 16
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  input  wire signed [15:0]    org_x,
  input  wire signed [15:0]    org_y,
  input  wire [15:0]           ring_min,
  input  wire [15:0]           ring_max,
  input  wire                  in_vld,
  input  wire [ANGLE_BITS:0]   in_ang,
  input  wire [31:0]           in_pt,
  input  wire                  in_tag,
  output logic                 have_any,
  output logic [31:0]          best_pt
);

  localparam int DW = ANGLE_BITS + 2;

  logic [ANGLE_BITS:0] ref_ang;
  logic [31:0] lo2, hi2;
  logic signed [16:0] dx, dy;
  logic [34:0] d2;
  logic ok_r, tag_r;
  logic [ANGLE_BITS:0] ang_r;
  logic [31:0] pt_r;
  logic [33:0] sq_x, sq_y;

  // offset of the stored point from the query origin
  assign dx = 17'(signed'(in_pt[31:16])) - 17'(org_x);
  assign dy = 17'(signed'(in_pt[15:0])) - 17'(org_y);

  // stage one: squared distance
  always_ff @(posedge clk) begin
    lo2 <= ring_min * ring_min;
    hi2 <= ring_max * ring_max;
    sq_x <= 34'(dx * dx);
    sq_y <= 34'(dy * dy);
    ok_r <= !rst && in_vld && !(dx == 0 && dy == 0) && !in_tag;
    tag_r <= !rst && in_vld && in_tag;
    ang_r <= in_ang;
    pt_r <= in_pt;
  end

  assign d2 = 35'(sq_x) + 35'(sq_y);

  logic signed [DW-1:0] diff;
  logic have_pos, have_neg, is_pos, win;
  logic signed [DW-1:0] pd, nd;
  logic [31:0] ppt, npt;
  logic cand;

  function automatic logic beats(input logic signed [DW-1:0] d, input logic [31:0] p,
                                 input logic signed [DW-1:0] bd, input logic [31:0] bp);
    begin
      if (d != bd) return d < bd;
      if (p[31:16] != bp[31:16]) return signed'(p[31:16]) < signed'(bp[31:16]);
      return signed'(p[15:0]) < signed'(bp[15:0]);
    end
  endfunction

  always_comb begin
    diff = DW'(ang_r) - DW'(ref_ang);
    cand = ok_r && d2 >= 35'(lo2) && d2 <= 35'(hi2);
    is_pos = !diff[DW-1];
    win = is_pos ? (!have_pos || beats(diff, pt_r, pd, ppt))
                 : (!have_neg || beats(diff, pt_r, nd, npt));
    have_any = have_pos || have_neg;
    best_pt = have_pos ? ppt : npt;
  end

  // stage two: a tagged word loads the reference angle; keep best nonnegative and best negative candidate
  always_ff @(posedge clk) begin
    if (rst || start) begin
      have_pos <= 1'b0;
      have_neg <= 1'b0;
    end else if (tag_r) begin
      ref_ang <= ang_r;
    end else if (cand && win) begin
      if (is_pos) begin
        have_pos <= 1'b1;
        pd <= diff;
        ppt <= pt_r;
      end else begin
        have_neg <= 1'b1;
        nd <= diff;
        npt <= pt_r;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/angular_next_neighbour_search_unit.sv
// Top level of the angular next neighbour search block.
// Usage: items enter on s_axis (tdata: operation, point_x, point_y, dir_x, dir_y from
// bit 0 up) and one result word per item leaves on m_axis (tdata: status, next_x,
// next_y, normal_x, normal_y from bit 0 up). cfg_we/cfg_addr/cfg_wdata write the ring
// radii (index 0 inner, 1 outer) while the block is idle.
// Clear empties the set. Insert reads the point memory once per stored entry for a
// duplicate check. Query streams every stored point one per cycle from the memory
// through a 28 stage CORDIC pipeline and a two stage filter and selector.
// One item is processed at a time; s_axis_tready is low during work. The result is
// held in the output register until m_axis_tready takes it, and the next item may be
// accepted meanwhile; its work waits only if it finishes before the word is taken.
// Reset (rst, synchronous) empties the set and sets the ring to 0..65535; memory
// contents are not cleared, as only entries below the count are ever read.
`default_nettype none
module angular_next_neighbour_search_unit
  import anns_pkg::*;
#(
  parameter int MAX_POINTS = 256,
  parameter int ANGLE_BITS = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire [71:0]  s_axis_tdata,   // operation, point_x, point_y, dir_x, dir_y
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [71:0] m_axis_tdata,   // status, next_x, next_y, normal_x, normal_y
  input  wire         cfg_we,
  input  wire         cfg_addr,
  input  wire [15:0]  cfg_wdata
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNTW = $clog2(MAX_POINTS + 1);
  localparam int DRAIN = CORDIC_STEPS + 4;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_QRY  = 3'd2;
  localparam logic [2:0] S_DRN  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state;
  logic [15:0] ring_min, ring_max;
  logic [CNTW-1:0] count, idx;
  logic [5:0] drain;
  logic [1:0] op;
  logic signed [15:0] px, py, vx, vy;
  logic dup, rd_pend;
  logic [31:0] mem [0:MAX_POINTS-1];
  logic [31:0] rd_data;
  logic [1:0] res_st;
  logic [31:0] res_pt;
  logic start;
  logic [71:0] res_word;

  wire in_acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE) && !rst;

  // register ring radii
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_min <= 16'd0;
      ring_max <= 16'hFFFF;
    end else if (cfg_we) begin
      if (cfg_addr == CFG_RING_MIN) ring_min <= cfg_wdata;
      else ring_max <= cfg_wdata;
    end
  end

  wire do_wr = (state == S_INS) && idx == count && !rd_pend && !dup
               && count != CNTW'(MAX_POINTS);
  wire do_rd = (state == S_INS || state == S_QRY) && idx < count;

  // point memory, one read and one write port
  always_ff @(posedge clk) begin
    if (do_wr) mem[idx[AW-1:0]] <= {px, py};
    if (do_rd) rd_data <= mem[idx[AW-1:0]];
  end

  logic        c_vld, c_tag;
  logic signed [16:0] c_x, c_y;
  logic [31:0] c_pt;

  // feed the angle unit: direction first, then stored points
  always_comb begin
    c_vld = 1'b0;
    c_tag = 1'b0;
    c_x = 17'(vx);
    c_y = 17'(vy);
    c_pt = rd_data;
    if (start) begin
      c_vld = 1'b1;
      c_tag = 1'b1;
    end else if (state inside {S_QRY, S_DRN} && rd_pend) begin
      c_vld = 1'b1;
      c_x = 17'(signed'(rd_data[31:16])) - 17'(px);
      c_y = 17'(signed'(rd_data[15:0])) - 17'(py);
    end
  end

  logic a_vld, a_tag, have_any;
  logic [ANGLE_BITS:0] a_ang;
  logic [31:0] a_pt, best_pt;

  anns_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
    .clk(clk), .rst(rst), .in_vld(c_vld), .in_x(c_x), .in_y(c_y),
    .in_pt(c_pt), .in_tag(c_tag),
    .out_vld(a_vld), .out_ang(a_ang), .out_pt(a_pt), .out_tag(a_tag)
  );

  anns_select #(.ANGLE_BITS(ANGLE_BITS)) u_select (
    .clk(clk), .rst(rst), .start(start), .org_x(px), .org_y(py),
    .ring_min(ring_min), .ring_max(ring_max),
    .in_vld(a_vld), .in_ang(a_ang), .in_pt(a_pt), .in_tag(a_tag),
    .have_any(have_any), .best_pt(best_pt)
  );

  // assemble the result word
  always_comb begin
    res_word = '0;
    res_word[1:0] = res_st;
    if (op == OP_QUERY && res_st == ST_OK) begin
      res_word[17:2] = res_pt[31:16];
      res_word[33:18] = res_pt[15:0];
      res_word[50:34] = 17'(signed'(res_pt[15:0])) - 17'(py);
      res_word[67:51] = 17'(px) - 17'(signed'(res_pt[31:16]));
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    start <= in_acc && (s_axis_tdata[1:0] == OP_QUERY);
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      rd_pend <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && state != S_DONE) m_axis_tvalid <= 1'b0;
      rd_pend <= do_rd;
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            op <= s_axis_tdata[1:0];
            px <= s_axis_tdata[17:2];
            py <= s_axis_tdata[33:18];
            vx <= s_axis_tdata[49:34];
            vy <= s_axis_tdata[65:50];
            idx <= '0;
            dup <= 1'b0;
            res_st <= ST_OK;
            res_pt <= '0;
            case (s_axis_tdata[1:0])
              OP_CLEAR: begin
                count <= '0;
                state <= S_DONE;
              end
              OP_INSERT: state <= S_INS;
              OP_QUERY: state <= S_QRY;
              default: state <= S_DONE;
            endcase
          end
        end
        S_INS: begin
          if (rd_pend && rd_data == {px, py}) dup <= 1'b1;
          if (idx < count) idx <= idx + 1'b1;
          else if (!rd_pend) begin
            if (!dup && !(rd_pend && rd_data == {px, py})) begin
              if (count == CNTW'(MAX_POINTS)) res_st <= ST_FULL;
              else count <= count + 1'b1;
            end
            state <= S_DONE;
          end
        end
        S_QRY: begin
          if (idx < count) idx <= idx + 1'b1;
          else begin
            drain <= 6'(DRAIN);
            state <= S_DRN;
          end
        end
        S_DRN: begin
          if (drain == 6'd0) begin
            res_st <= have_any ? ST_OK : ST_NONE;
            res_pt <= have_any ? best_pt : 32'd0;
            state <= S_DONE;
          end else drain <= drain - 1'b1;
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata <= res_word;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: tb/sv/anns_result_checker.sv
// Result checker: tracks the point set, predicts each result word and compares it.
`default_nettype none
module anns_result_checker
  import anns_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  input  wire         s_axis_tready,
  input  wire [71:0]  s_axis_tdata,   // operation, point_x, point_y, dir_x, dir_y
  input  wire         m_axis_tvalid,
  input  wire         m_axis_tready,
  input  wire [71:0]  m_axis_tdata,   // status, next_x, next_y, normal_x, normal_y
  input  wire         cfg_we,
  input  wire         cfg_addr,
  input  wire [15:0]  cfg_wdata,
  output int          fail_count,
  output int          pending,
  output int          found_count,
  output int          none_count,
  output int          full_count
);

  localparam int SET_DEPTH = 256;

  typedef struct {
    logic [1:0]         status;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [16:0] normx;
    logic signed [16:0] normy;
  } search_result_t;

  // arctangent of 2^-i, in 2^-32 turn
  localparam logic [31:0] ATAN_TURNS [28] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41721, 32'd20860,
    32'd10430, 32'd5215, 32'd2607, 32'd1303, 32'd651, 32'd325, 32'd162,
    32'd81, 32'd40, 32'd20, 32'd10, 32'd5
  };

  logic signed [15:0] set_x [SET_DEPTH];
  logic signed [15:0] set_y [SET_DEPTH];
  int                 set_size;
  logic [15:0]        ring_lo;
  logic [15:0]        ring_hi;
  search_result_t     result_queue [$];

  // angle of a vector in (0, 65536], turns of 2^-16
  function automatic longint vector_angle(input longint x, input longint y);
    logic [31:0] z;
    longint      cx, cy, sx, sy;
    if (y == 0) begin
      z = (x < 0) ? 32'h8000_0000 : 32'h0;
    end else if (x == 0) begin
      z = (y > 0) ? 32'h4000_0000 : 32'hC000_0000;
    end else begin
      cx = x * 16384;
      cy = y * 16384;
      z  = 32'h0;
      if (cx < 0) begin
        cx = -cx;
        cy = -cy;
        z  = 32'h8000_0000;
      end
      for (int i = 0; i < 28; i++) begin
        sx = cx >>> i;
        sy = cy >>> i;
        if (cy > 0) begin
          cx = cx + sy;
          cy = cy - sx;
          z  = z + ATAN_TURNS[i];
        end else begin
          cx = cx - sy;
          cy = cy + sx;
          z  = z - ATAN_TURNS[i];
        end
      end
    end
    return (z[31:16] == 16'd0) ? 65536 : longint'(z[31:16]);
  endfunction

  // true when candidate (d,x,y) ranks ahead of the held best
  function automatic bit ranks_ahead(input longint d, input longint x, input longint y,
                                     input longint bd, input longint bx, input longint by);
    if (d != bd) return d < bd;
    if (x != bx) return x < bx;
    return y < by;
  endfunction

  // update the point set and work out the result word for one input word
  function automatic search_result_t predict_item(input logic [71:0] word);
    search_result_t r;
    logic [1:0]     op;
    longint         px, py, vx, vy, qx, qy, ddx, ddy, d2, lo2, hi2, refa, diff;
    longint         pd, pbx, pby, nd, nbx, nby, bx, by;
    bit             have_pos, have_neg, dup;
    op = word[1:0];
    px = longint'($signed(word[17:2]));
    py = longint'($signed(word[33:18]));
    vx = longint'($signed(word[49:34]));
    vy = longint'($signed(word[65:50]));
    r  = '{ST_OK, 16'sd0, 16'sd0, 17'sd0, 17'sd0};
    case (op)
      OP_CLEAR: begin
        set_size = 0;
      end
      OP_INSERT: begin
        dup = 1'b0;
        for (int i = 0; i < set_size; i++)
          if (set_x[i] == px[15:0] && set_y[i] == py[15:0]) dup = 1'b1;
        if (!dup) begin
          if (set_size >= SET_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            set_x[set_size] = px[15:0];
            set_y[set_size] = py[15:0];
            set_size++;
          end
        end
      end
      OP_QUERY: begin
        refa = vector_angle(vx, vy);
        lo2 = longint'(ring_lo) * longint'(ring_lo);
        hi2 = longint'(ring_hi) * longint'(ring_hi);
        have_pos = 1'b0;
        have_neg = 1'b0;
        pd = 0; pbx = 0; pby = 0; nd = 0; nbx = 0; nby = 0;
        for (int i = 0; i < set_size; i++) begin
          qx  = longint'(set_x[i]);
          qy  = longint'(set_y[i]);
          ddx = qx - px;
          ddy = qy - py;
          d2  = ddx * ddx + ddy * ddy;
          if ((ddx != 0 || ddy != 0) && d2 >= lo2 && d2 <= hi2) begin
            diff = vector_angle(ddx, ddy) - refa;
            if (diff >= 0) begin
              if (!have_pos || ranks_ahead(diff, qx, qy, pd, pbx, pby)) begin
                have_pos = 1'b1; pd = diff; pbx = qx; pby = qy;
              end
            end else if (!have_neg || ranks_ahead(diff, qx, qy, nd, nbx, nby)) begin
              have_neg = 1'b1; nd = diff; nbx = qx; nby = qy;
            end
          end
        end
        if (have_pos || have_neg) begin
          bx = have_pos ? pbx : nbx;
          by = have_pos ? pby : nby;
          r.nx    = bx[15:0];
          r.ny    = by[15:0];
          r.normx = 17'(by - py);
          r.normy = 17'(px - bx);
        end else begin
          r.status = ST_NONE;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // track config, predict accepted words, compare delivered words
  always @(posedge clk) begin
    search_result_t e;
    if (rst) begin
      set_size = 0;
      ring_lo  <= 16'd0;
      ring_hi  <= 16'hFFFF;
      result_queue.delete();
      pending <= 0;
      fail_count <= 0;
      found_count <= 0;
      none_count <= 0;
      full_count <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == CFG_RING_MIN) ring_lo <= cfg_wdata;
        else ring_hi <= cfg_wdata;
      end
      if (s_axis_tvalid && s_axis_tready)
        result_queue.insert(result_queue.size(), predict_item(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_queue.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, m_axis_tdata);
          fail_count <= fail_count + 1;
        end else begin
          e = result_queue.pop_front();
          if (m_axis_tdata[1:0] != e.status || m_axis_tdata[17:2] != e.nx ||
              m_axis_tdata[33:18] != e.ny || m_axis_tdata[50:34] != e.normx ||
              m_axis_tdata[67:51] != e.normy) begin
            $display("%0t: mismatch expected st=%0d next=(%0d,%0d) normal=(%0d,%0d)",
                     $time, e.status, e.nx, e.ny, e.normx, e.normy);
            $display("%0t:          actual   st=%0d next=(%0d,%0d) normal=(%0d,%0d)",
                     $time, m_axis_tdata[1:0], $signed(m_axis_tdata[17:2]),
                     $signed(m_axis_tdata[33:18]), $signed(m_axis_tdata[50:34]),
                     $signed(m_axis_tdata[67:51]));
            fail_count <= fail_count + 1;
          end
          if (e.status == ST_NONE) none_count <= none_count + 1;
          else if (e.status == ST_FULL) full_count <= full_count + 1;
          else if (e.nx != 0 || e.ny != 0 || e.normx != 0 || e.normy != 0)
            found_count <= found_count + 1;
        end
      end
      pending <= result_queue.size();
    end
  end

endmodule
`default_nettype wire

FILE: tb/sv/angular_next_neighbour_search_unit_tb.sv
// Testbench top: clock, reset, stimulus, receiver stalls and the verdict.
`default_nettype none
module angular_next_neighbour_search_unit_tb;
  import anns_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  wire         s_axis_tready;
  logic [71:0] s_axis_tdata = '0;   // operation, point_x, point_y, dir_x, dir_y
  wire         m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire  [71:0] m_axis_tdata;        // status, next_x, next_y, normal_x, normal_y
  logic        cfg_we = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [15:0] cfg_wdata = '0;

  int fail_count, pending, found_count, none_count, full_count;
  int items_sent;
  int phase_count;
  bit idle_on;
  bit long_hold_req;

  angular_next_neighbour_search_unit u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  anns_result_checker u_checker (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending), .found_count(found_count),
    .none_count(none_count), .full_count(full_count)
  );

  always #5 clk = ~clk;

  // give up long after the slowest correct run
  initial begin
    #50_000_000;
    $display("[angular_next_neighbour_search_unit] ERROR");
    $finish;
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall = 600;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(0, 5);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // offer one word, with an optional idle burst first; returns at the accepting edge
  task automatic send_word(input logic [1:0] op, input logic [15:0] px,
                           input logic [15:0] py, input logic [15:0] vx,
                           input logic [15:0] vy);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, vy, vx, py, px, op};
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  // drop valid, drain all results, then write one ring register
  task automatic write_ring(input logic sel, input logic [15:0] value);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= sel;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] near_coord(input logic [15:0] base);
    return base + 16'($urandom_range(0, 160)) - 16'd80;
  endfunction

  function automatic logic [15:0] any_dir();
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return 16'($urandom_range(0, 8)) - 16'd4;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] bx, by, rlo, rhi;
    logic [15:0] px [$];
    logic [15:0] py [$];
    int          n_ins, n_q, k;
    bit          big;
    idle_on = 1'b1;
    long_hold_req = 1'b0;
    items_sent = 0;
    phase_count = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty set, extremes, duplicates, axes, ties, unused op
    send_word(OP_QUERY, 16'd0, 16'd0, 16'd1, 16'd0);
    send_word(OP_INSERT, 16'h8000, 16'h8000, 16'd0, 16'd0);
    send_word(OP_INSERT, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF);
    send_word(OP_INSERT, 16'h7FFF, 16'h7FFF, 16'd0, 16'd0);
    send_word(OP_INSERT, 16'd0, 16'd0, 16'd0, 16'd0);
    send_word(OP_INSERT, 16'd16, 16'd0, 16'd0, 16'd0);
    send_word(OP_INSERT, -16'sd16, 16'd0, 16'd0, 16'd0);
    send_word(OP_INSERT, 16'd0, 16'd16, 16'd0, 16'd0);
    send_word(OP_INSERT, 16'd0, -16'sd16, 16'd0, 16'd0);
    send_word(OP_INSERT, 16'd16, 16'd16, 16'd0, 16'd0);
    send_word(OP_INSERT, 16'd32, 16'd32, 16'd0, 16'd0);
    send_word(OP_QUERY, 16'd0, 16'd0, 16'd0, 16'd0);
    send_word(OP_QUERY, 16'd0, 16'd0, 16'd1, 16'd1);
    send_word(OP_QUERY, 16'd0, 16'd0, 16'hFFFF, 16'd0);
    send_word(OP_QUERY, 16'd0, 16'd0, 16'd0, 16'h8000);
    send_word(OP_QUERY, 16'd0, 16'd0, 16'h7FFF, 16'h8000);
    send_word(OP_QUERY, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
    send_word(OP_QUERY, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h0001);
    send_word(2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(OP_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(OP_QUERY, 16'd0, 16'd0, 16'd1, 16'd0);

    // random phases: ring setting, clear, fill, queries
    while (items_sent < 1650) begin
      case (phase_count % 7)
        0: begin rlo = 16'd0;     rhi = 16'hFFFF; end
        1: begin rlo = 16'd0;     rhi = 16'd0;    end
        2: begin rlo = 16'hFFFF;  rhi = 16'hFFFF; end
        3: begin rlo = 16'd20;    rhi = 16'd90;   end
        default: begin
          rlo = 16'($urandom_range(0, 60));
          rhi = rlo + 16'($urandom_range(0, 120));
        end
      endcase
      if (items_sent > 1450) idle_on = 1'b0;
      write_ring(CFG_RING_MIN, rlo);
      write_ring(CFG_RING_MAX, rhi);
      send_word(OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      px.delete();
      py.delete();
      bx = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 64));
      by = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 64));
      big   = (phase_count % 6 == 5) && (items_sent < 1300);
      n_ins = big ? 300 : $urandom_range(1, 30);
      n_q   = big ? 6 : $urandom_range(8, 24);
      for (int i = 0; i < n_ins; i++) begin
        if (px.size() > 0 && $urandom_range(0, 7) == 0) begin
          k = $urandom_range(0, px.size() - 1);
          send_word(OP_INSERT, px[k], py[k], 16'($urandom), 16'($urandom));
        end else begin
          px.insert(px.size(),
                    ($urandom_range(0, 9) == 0) ? 16'($urandom) : near_coord(bx));
          py.insert(py.size(),
                    ($urandom_range(0, 9) == 0) ? 16'($urandom) : near_coord(by));
          send_word(OP_INSERT, px[$], py[$], 16'($urandom), 16'($urandom));
        end
      end
      if (phase_count == 2) long_hold_req = 1'b1;
      for (int i = 0; i < n_q; i++) begin
        k = $urandom_range(0, px.size() - 1);
        case ($urandom_range(0, 9))
          0: send_word(2'd3, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
          1: send_word(OP_QUERY, 16'($urandom), 16'($urandom), any_dir(), any_dir());
          2, 3, 4: send_word(OP_QUERY, near_coord(bx), near_coord(by), any_dir(), any_dir());
          default: send_word(OP_QUERY, px[k], py[k], any_dir(), any_dir());
        endcase
      end
      phase_count++;
    end
    s_axis_tvalid <= 1'b0;

    // drain, then allow the block's latency
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("Run covered %0d words over %0d ring settings plus directed cases.",
             items_sent, phase_count);
    $display("Results: %0d neighbours found, %0d none in ring, %0d inserts into full set.",
             found_count, none_count, full_count);
    if (fail_count == 0) begin
      $display("[angular_next_neighbour_search_unit] OK");
    end else begin
      $display("[angular_next_neighbour_search_unit] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
